>>> hdl/updec_pkg.sv
// ----------------------------------------------------------------------------
// updec_pkg
// Shared types, constants and character helpers for the percent decoder.
// ----------------------------------------------------------------------------
package updec_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Byte count of one job: 1 to 3 result bytes
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    // Byte slot inside a job
    localparam logic [1:0] SLOT_0 = 2'd0;
    localparam logic [1:0] SLOT_1 = 2'd1;
    localparam logic [1:0] SLOT_2 = 2'd2;

    // One classified input: the result bytes it causes
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] cnt;
        logic       last;
    } job_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h30) && (c <= 8'h39)) ||
            ((c >= 8'h41) && (c <= 8'h46)) ||
            ((c >= 8'h61) && (c <= 8'h66));
        return r;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            d = c - 8'h30;
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            d = c - 8'h37;
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            d = c - 8'h57;
        end
        return d[3:0];
    endfunction

endpackage

>>> hdl/updec_front.sv
// ----------------------------------------------------------------------------
// updec_front
// Accepts input transactions, tracks the escape sequence and builds jobs.
// ----------------------------------------------------------------------------
module updec_front
    import updec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       push,
    output job_t       job
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_HELD = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic       emit;

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        emit       = 1'b0;
        job.byte0  = in_byte;
        job.byte1  = in_byte;
        job.byte2  = in_byte;
        job.cnt    = CNT_ONE;
        job.last   = in_last;
        unique case (phase_reg)
            PH_PCT:
            begin
                if (in_last)
                begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                    if (is_hex(in_byte))
                    begin
                        job.byte0 = {4'h0, hex_val(in_byte)};
                    end
                    else
                    begin
                        job.byte0 = CH_PERCENT;
                        job.cnt   = CNT_TWO;
                    end
                end
                else
                begin
                    held_next  = in_byte;
                    phase_next = PH_HELD;
                end
            end
            PH_HELD:
            begin
                emit       = 1'b1;
                phase_next = PH_IDLE;
                if (is_hex(held_reg) && is_hex(in_byte))
                begin
                    job.byte0 = {hex_val(held_reg), hex_val(in_byte)};
                end
                else
                begin
                    job.byte0 = CH_PERCENT;
                    job.byte1 = held_reg;
                    job.cnt   = CNT_THREE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if ((in_byte == CH_PERCENT) && !in_last)
                begin
                    phase_next = PH_PCT;
                end
                else
                begin
                    emit = 1'b1;
                    if (in_byte == CH_PLUS)
                    begin
                        job.byte0 = CH_SPACE;
                    end
                end
            end
        endcase
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

>>> hdl/updec_queue.sv
// ----------------------------------------------------------------------------
// updec_queue
// Short job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module updec_queue
    import updec_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> hdl/updec_back.sv
// ----------------------------------------------------------------------------
// updec_back
// Unrolls each job into result transactions through an output register.
// ----------------------------------------------------------------------------
module updec_back
    import updec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  job_t       head_job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_end,
    output logic       stream_end
);

    logic [1:0] slot_reg, slot_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       run_reg, run_next;
    logic       strm_reg, strm_next;
    logic       load;
    logic       final_slot;

    assign load       = (!valid_reg || out_ready) && head_valid;
    assign final_slot = ((slot_reg + 2'd1) == head_job.cnt);
    assign pop        = load && final_slot;

    always_comb
    begin
        slot_next  = slot_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        run_next   = run_reg;
        strm_next  = strm_reg;
        if (load)
        begin
            valid_next = 1'b1;
            run_next   = final_slot;
            strm_next  = final_slot && head_job.last;
            unique case (slot_reg)
                SLOT_0:  byte_next = head_job.byte0;
                SLOT_1:  byte_next = head_job.byte1;
                default: byte_next = head_job.byte2;
            endcase
            // advance to the next byte, or rewind once the job is drained
            slot_next = final_slot ? SLOT_0 : slot_reg + 2'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= SLOT_0;
            valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        run_reg  <= run_next;
        strm_reg <= strm_next;
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign run_end    = run_reg;
    assign stream_end = strm_reg;

endmodule

>>> hdl/url_percent_decoder_top.sv
// ----------------------------------------------------------------------------
// url_percent_decoder_top
// Streaming URL percent decoder, one encoded byte in per transaction.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): in_byte plus in_last marking the final
// character of a string. Output channel (out_valid/out_ready): out_byte,
// run_end on the last result of one input, stream_end on the last result of
// a string.
// The front decodes "%hh" escapes and '+' and pushes a job of one to three
// result bytes into a four-entry queue; a '%' and the character after it
// push nothing unless they end a string. The back drains each job one result
// per cycle while out_ready is high, through a registered output stage.
// Path: an accepted input's job enters the queue, then its first result
// loads into the output register; further results of the same input follow
// one per cycle while out_ready is high. Throughput: one input per cycle
// while in_ready is high, one result per cycle while out_ready is high; three
// results follow only after two silent inputs, so one byte per cycle is sustained.
// Reset: the escape tracker returns outside an escape and the queue and the
// output stage empty.
// Stall: while out_ready is low the output holds; the queue fills and
// in_ready drops once all four entries are occupied.
// ----------------------------------------------------------------------------
module url_percent_decoder_top
    import updec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_end,
    output logic       stream_end
);

    logic accept;
    logic push;
    logic full;
    logic pop;
    logic head_valid;
    job_t front_job;
    job_t head_job;

    // accept whenever the queue has room for a possible job
    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    updec_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .in_last (in_last),
        .push    (push),
        .job     (front_job)
    );

    updec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (front_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    updec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_end    (run_end),
        .stream_end (stream_end)
    );

endmodule

>>> test/url_percent_decoder_top_test.sv
// ----------------------------------------------------------------------------
// url_percent_decoder_top_test
// Self-checking bench for the streaming URL percent decoder.
// ----------------------------------------------------------------------------
// A queue of encoded characters feeds a clocked driver on the input channel.
// A clocked monitor decodes every accepted input transaction with a local
// model of the escape tracker. It then checks each output transaction, field
// by field, against the oldest decoded character still owed. Both channels
// idle at random, with stretches of back-to-back traffic in between.
// ----------------------------------------------------------------------------
module url_percent_decoder_top_test
    import updec_pkg::*;
;

    // Escape tracker of the local decoder model
    typedef enum logic [1:0]
    {
        ESC_IDLE,
        ESC_PERCENT,
        ESC_ONE_CHAR
    } esc_phase_t;

    // One encoded character waiting to be driven, with its idle lead-in
    typedef struct
    {
        logic [7:0]  ch;
        logic        last;
        int unsigned gap;
    } enc_char_t;

    // One decoded character owed by the block
    typedef struct packed
    {
        logic [7:0] ch;
        logic       run_end;
        logic       stream_end;
    } dec_char_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte   = 8'h00;
    logic       in_last   = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       run_end;
    logic       stream_end;

    enc_char_t   pending_chars [$];
    dec_char_t   decoded_q [$];
    enc_char_t   cur_char;
    dec_char_t   want;
    esc_phase_t  esc_phase    = ESC_IDLE;
    logic [7:0]  held_char    = 8'h00;
    logic        char_loaded  = 1'b0;
    logic        in_taken     = 1'b0;
    logic        out_taken    = 1'b0;
    logic        quiet_in     = 1'b0;
    logic        quiet_out    = 1'b0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned chars_total  = 0;
    int unsigned chars_taken  = 0;
    int unsigned errors       = 0;

    url_percent_decoder_top dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_end    (run_end),
        .stream_end (stream_end)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // Local decoder model
    // ------------------------------------------------------------------------
    function automatic logic hex_char_ok(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
               (c >= "a" && c <= "f");
    endfunction

    function automatic logic [7:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return c - "0";
        end
        if (c >= "A" && c <= "F")
        begin
            return c - "A" + 8'd10;
        end
        if (c >= "a" && c <= "f")
        begin
            return c - "a" + 8'd10;
        end
        return 8'h00;
    endfunction

    // Decode one accepted character; append the characters it owes.
    task automatic decode_char(input logic [7:0] c, input logic last);
        logic [7:0] res [0:2];
        logic [7:0] hi_nib;
        logic [7:0] lo_nib;
        int         n;
        n = 0;
        case (esc_phase)
            ESC_PERCENT:
            begin
                if (last)
                begin
                    // string ends one character into an escape
                    if (hex_char_ok(c))
                    begin
                        res[0] = nibble_of(c);
                        n = 1;
                    end
                    else
                    begin
                        res[0] = CH_PERCENT;
                        res[1] = c;
                        n = 2;
                    end
                    esc_phase = ESC_IDLE;
                end
                else
                begin
                    held_char = c;
                    esc_phase = ESC_ONE_CHAR;
                end
            end
            ESC_ONE_CHAR:
            begin
                if (hex_char_ok(held_char) && hex_char_ok(c))
                begin
                    hi_nib = nibble_of(held_char);
                    lo_nib = nibble_of(c);
                    res[0] = {hi_nib[3:0], lo_nib[3:0]};
                    n = 1;
                end
                else
                begin
                    // broken escape: pass all three raw, no plus mapping
                    res[0] = CH_PERCENT;
                    res[1] = held_char;
                    res[2] = c;
                    n = 3;
                end
                esc_phase = ESC_IDLE;
            end
            default:
            begin
                esc_phase = ESC_IDLE;
                if (c == CH_PERCENT && !last)
                begin
                    esc_phase = ESC_PERCENT;
                end
                else if (c == CH_PLUS)
                begin
                    res[0] = CH_SPACE;
                    n = 1;
                end
                else
                begin
                    res[0] = c;
                    n = 1;
                end
            end
        endcase
        for (int k = 0; k < n; k++)
        begin
            decoded_q.insert(decoded_q.size(),
                             {res[k], k == n - 1, (k == n - 1) && last});
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_char(input logic [7:0] ch, input logic last);
        enc_char_t e;
        // flip between idling and back-to-back stretches now and then
        if ($urandom_range(0, 15) == 0)
        begin
            quiet_in = ~quiet_in;
        end
        e.ch   = ch;
        e.last = last;
        e.gap  = quiet_in ? 0 : $urandom_range(0, 7);
        pending_chars.insert(pending_chars.size(), e);
    endfunction

    function automatic logic [7:0] rand_hex_char();
        logic [7:0] v;
        v = 8'($urandom_range(0, 15));
        if (v < 10)
        begin
            return "0" + v;
        end
        return ($urandom_range(0, 1) ? "A" : "a") + v - 8'd10;
    endfunction

    // Non-hex character, mostly the neighbors of the hex ranges
    function automatic logic [7:0] rand_nonhex_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0: c = 8'h2F;
            1: c = 8'h3A;
            2: c = 8'h40;
            3: c = 8'h47;
            4: c = 8'h60;
            5: c = 8'h67;
            6: c = CH_PLUS;
            7: c = CH_PERCENT;
            default:
            begin
                c = 8'($urandom_range(0, 255));
                while (hex_char_ok(c))
                begin
                    c = 8'($urandom_range(0, 255));
                end
            end
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus: directed strings first, then random token streams
    // ------------------------------------------------------------------------
    initial
    begin
        // byte extremes pass through; the second ends a string
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b1);
        // plus maps to space
        queue_char(CH_PLUS, 1'b0);
        // upper, mixed and zero escapes; the first ends on its last digit
        queue_char(CH_PERCENT, 1'b0);
        queue_char("4", 1'b0);
        queue_char("1", 1'b1);
        queue_char(CH_PERCENT, 1'b0);
        queue_char("f", 1'b0);
        queue_char("F", 1'b0);
        queue_char(CH_PERCENT, 1'b0);
        queue_char("0", 1'b0);
        queue_char("0", 1'b0);
        // broken escapes: bad first char (a plus, kept raw), bad second char
        queue_char(CH_PERCENT, 1'b0);
        queue_char(CH_PLUS, 1'b0);
        queue_char("1", 1'b0);
        queue_char(CH_PERCENT, 1'b0);
        queue_char("9", 1'b0);
        queue_char("g", 1'b0);
        // trailing lone percent
        queue_char(CH_PERCENT, 1'b1);
        // percent then one last hex digit, then one last non-hex char
        queue_char(CH_PERCENT, 1'b0);
        queue_char("a", 1'b1);
        queue_char(CH_PERCENT, 1'b0);
        queue_char("x", 1'b1);
        // plus as the end of a string
        queue_char(CH_PLUS, 1'b1);

        while (pending_chars.size() < 150)
        begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4:
                begin
                    queue_char(CH_PERCENT, 1'b0);
                    queue_char(rand_hex_char(), 1'b0);
                    queue_char(rand_hex_char(), $urandom_range(0, 5) == 0);
                end
                5, 6, 7:
                begin
                    queue_char(CH_PERCENT, 1'b0);
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            queue_char(rand_nonhex_char(), 1'b0);
                            queue_char(rand_hex_char(), $urandom_range(0, 5) == 0);
                        end
                        1:
                        begin
                            queue_char(rand_hex_char(), 1'b0);
                            queue_char(rand_nonhex_char(), $urandom_range(0, 5) == 0);
                        end
                        default:
                        begin
                            queue_char(rand_nonhex_char(), 1'b0);
                            queue_char(rand_nonhex_char(), $urandom_range(0, 5) == 0);
                        end
                    endcase
                end
                8, 9:
                begin
                    queue_char(CH_PLUS, $urandom_range(0, 5) == 0);
                end
                10, 11, 12:
                begin
                    queue_char(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
                end
                13:
                begin
                    // string cut short inside an escape
                    if ($urandom_range(0, 1))
                    begin
                        queue_char(CH_PERCENT, 1'b1);
                    end
                    else
                    begin
                        queue_char(CH_PERCENT, 1'b0);
                        queue_char($urandom_range(0, 1) ? rand_hex_char()
                                                        : rand_nonhex_char(), 1'b1);
                    end
                end
                default:
                begin
                    // raw noise with random string ends
                    repeat ($urandom_range(1, 3))
                    begin
                        queue_char(8'($urandom_range(0, 255)),
                                   $urandom_range(0, 1) == 1);
                    end
                end
            endcase
        end
        chars_total = pending_chars.size();
    end

    // ------------------------------------------------------------------------
    // Reset, end of run
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // drain: every character accepted, every decoded character seen
        while (chars_taken < chars_total || chars_total == 0)
        begin
            @(posedge clk);
        end
        while (decoded_q.size() != 0)
        begin
            @(posedge clk);
        end
        // hold a little longer to catch stray output transactions
        repeat (10) @(posedge clk);
        if (errors == 0)
        begin
            $display("PASS url_percent_decoder_top");
        end
        else
        begin
            $display("FAIL url_percent_decoder_top");
        end
        $finish;
    end

    initial
    begin
        #400000;
        $display("FAIL url_percent_decoder_top");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input driver: change at the falling edge, hold until accepted
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                in_taken = 1'b0;
                if (!char_loaded && pending_chars.size() != 0)
                begin
                    cur_char    = pending_chars.pop_front();
                    char_loaded = 1'b1;
                    gap_left    = cur_char.gap;
                end
                if (char_loaded && gap_left == 0)
                begin
                    in_valid    <= 1'b1;
                    in_byte     <= cur_char.ch;
                    in_last     <= cur_char.last;
                    char_loaded = 1'b0;
                end
                else
                begin
                    // idle for the drawn gap before the next transaction
                    in_valid <= 1'b0;
                    if (char_loaded)
                    begin
                        gap_left--;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output backpressure: stall a drawn number of cycles after each result
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                out_taken = 1'b0;
                if ($urandom_range(0, 31) == 0)
                begin
                    quiet_out = ~quiet_out;
                end
                stall_left = quiet_out ? 0 : $urandom_range(0, 7);
            end
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: decode accepted inputs first, then check accepted outputs
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                decode_char(in_byte, in_last);
                in_taken = 1'b1;
                chars_taken++;
            end
            if (out_valid && out_ready)
            begin
                out_taken = 1'b1;
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual byte %02h",
                             $time, out_byte);
                    errors++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_byte !== want.ch)
                    begin
                        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                                 $time, want.ch, out_byte);
                        errors++;
                    end
                    if (run_end !== want.run_end)
                    begin
                        $display("%0t: run_end mismatch: expected %0b, actual %0b",
                                 $time, want.run_end, run_end);
                        errors++;
                    end
                    if (stream_end !== want.stream_end)
                    begin
                        $display("%0t: stream_end mismatch: expected %0b, actual %0b",
                                 $time, want.stream_end, stream_end);
                        errors++;
                    end
                end
            end
        end
    end

endmodule
